>>> rtl/lrg_pkg.sv
// Package: constants, codes, state and control types of the linear ramp generator.
`default_nettype none
package lrg_pkg;

    localparam int BLOCK_SIZE = 64;
    localparam int FRAC_BITS  = 18;

    // dividend width of the block step division: 32-bit level shifted up by FRAC_BITS
    localparam int DIV_W   = 32 + FRAC_BITS;
    localparam int DCNT_W  = $clog2(DIV_W);
    localparam int SCNT_W  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_OVER_N   = 2'd1;

    localparam logic [30:0] TICKS_PER_MS_RST = 31'd180634;
    localparam logic [30:0] ONE_OVER_N_RST   = 31'd4096;

    typedef enum logic [1:0] {
        OP_SET_TARGET = 2'd0,
        OP_SET_TIME   = 2'd1,
        OP_STOP       = 2'd2,
        OP_TICK       = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_N,
        ST_LOAD_N,
        ST_DIV,
        ST_DIV_FIN,
        ST_MUL_S,
        ST_LOAD_S,
        ST_PREP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic mul_n;
        logic load_n;
        logic div_step;
        logic div_fin;
        logic mul_s;
        logic load_s;
        logic prep;
        logic emit_beat;
    } ctrl_cmd_t;

    typedef struct packed {
        logic retarget;
        logic div_last;
        logic last_beat;
    } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/lrg_if.sv
// Interfaces: event input, sample output and configuration write channels.
`default_nettype none
interface lrg_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] value;
    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

interface lrg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    logic               last;
    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

interface lrg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lrg_pkg::CFG_IDX_W-1:0]  index;
    logic [31:0]                    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/lrg_ctrl.sv
// Controller: sequences event decode, retarget math and block emission.
`default_nettype none
module lrg_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                din_valid,
    input  wire logic [1:0]          din_op,
    output logic                     din_ready,
    output logic                     dout_valid,
    input  wire logic                dout_ready,
    input  wire lrg_pkg::dp_status_t status,
    output lrg_pkg::ctrl_cmd_t       cmd
);

    lrg_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        din_ready  = 1'b0;
        dout_valid = 1'b0;
        unique case (state_reg)
            lrg_pkg::ST_IDLE:
            begin
                din_ready = 1'b1;
                if (din_valid)
                begin
                    cmd.accept = 1'b1;
                    if (lrg_pkg::op_t'(din_op) == lrg_pkg::OP_TICK)
                    begin
                        state_next = status.retarget ? lrg_pkg::ST_MUL_N : lrg_pkg::ST_PREP;
                    end
                end
            end
            lrg_pkg::ST_MUL_N:
            begin
                cmd.mul_n  = 1'b1;
                state_next = lrg_pkg::ST_LOAD_N;
            end
            lrg_pkg::ST_LOAD_N:
            begin
                cmd.load_n = 1'b1;
                state_next = lrg_pkg::ST_DIV;
            end
            lrg_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = lrg_pkg::ST_DIV_FIN;
                end
            end
            lrg_pkg::ST_DIV_FIN:
            begin
                cmd.div_fin = 1'b1;
                state_next  = lrg_pkg::ST_MUL_S;
            end
            lrg_pkg::ST_MUL_S:
            begin
                cmd.mul_s  = 1'b1;
                state_next = lrg_pkg::ST_LOAD_S;
            end
            lrg_pkg::ST_LOAD_S:
            begin
                cmd.load_s = 1'b1;
                state_next = lrg_pkg::ST_PREP;
            end
            lrg_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = lrg_pkg::ST_EMIT;
            end
            lrg_pkg::ST_EMIT:
            begin
                dout_valid = 1'b1;
                if (dout_ready)
                begin
                    cmd.emit_beat = 1'b1;
                    if (status.last_beat)
                    begin
                        state_next = lrg_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lrg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/lrg_dp.sv
// Datapath: ramp state, config registers, shared multiplier, serial divider, sample accumulator.
`default_nettype none
module lrg_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lrg_pkg::ctrl_cmd_t              cmd,
    output lrg_pkg::dp_status_t                  status,
    input  wire logic [1:0]                      din_op,
    input  wire logic [31:0]                     din_value,
    input  wire logic                            cfg_we,
    input  wire logic [lrg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [31:0]                     cfg_data,
    output logic [31:0]                          sample,
    output logic                                 last
);

    localparam int FB = lrg_pkg::FRAC_BITS;
    localparam int DW = lrg_pkg::DIV_W;

    logic [30:0] ticks_reg;
    logic [30:0] oon_reg;
    logic [31:0] target_reg;
    logic [31:0] current_reg;
    logic [31:0] block_step_reg;
    logic [31:0] sample_step_reg;
    logic [31:0] blocks_left_reg;
    logic [31:0] armed_reg;
    logic [31:0] pending_reg;
    logic        retarget_reg;

    logic [63:0]                    prod_reg;
    logic [31:0]                    rem_reg;
    logic [DW-1:0]                  quo_reg;
    logic [31:0]                    den_reg;
    logic                           qneg_reg;
    logic [lrg_pkg::DCNT_W-1:0]     dcnt_reg;
    logic [31:0]                    acc_reg;
    logic                           ramp_reg;
    logic [lrg_pkg::SCNT_W-1:0]     scnt_reg;

    logic signed [31:0] mul_x;
    logic signed [31:0] mul_y;
    logic signed [63:0] prod;
    logic [31:0]        n_raw;
    logic [31:0]        n_val;
    logic [31:0]        diff;
    logic [DW-1:0]      num;
    logic [DW-1:0]      num_mag;
    logic [31:0]        den_mag;
    logic [32:0]        trial;
    logic [32:0]        trial_sub;
    logic               trial_ge;
    logic [31:0]        quo_low;

    // one multiplier shared by block count and per-sample step
    assign mul_x = cmd.mul_s ? $signed(block_step_reg) : $signed(armed_reg);
    assign mul_y = cmd.mul_s ? $signed({1'b0, oon_reg}) : $signed({1'b0, ticks_reg});
    assign prod  = mul_x * mul_y;

    assign n_raw   = prod_reg[FB+31:FB];
    assign n_val   = (n_raw == 32'd0) ? (32'd1 << FB) : n_raw;
    assign diff    = target_reg - current_reg;
    assign num     = {diff, {FB{1'b0}}};
    assign num_mag = diff[31] ? (~num + {{(DW-1){1'b0}}, 1'b1}) : num;
    assign den_mag = n_val[31] ? (~n_val + 32'd1) : n_val;

    // restoring divide, one quotient bit per cycle
    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign trial_ge  = (trial >= {1'b0, den_reg});
    assign quo_low   = quo_reg[31:0];

    assign status.retarget  = retarget_reg;
    assign status.div_last  = (dcnt_reg == lrg_pkg::DCNT_W'(DW - 1));
    assign status.last_beat = (scnt_reg == lrg_pkg::SCNT_W'(lrg_pkg::BLOCK_SIZE - 1));

    assign sample = acc_reg;
    assign last   = status.last_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg       <= lrg_pkg::TICKS_PER_MS_RST;
            oon_reg         <= lrg_pkg::ONE_OVER_N_RST;
            target_reg      <= '0;
            current_reg     <= '0;
            block_step_reg  <= '0;
            sample_step_reg <= '0;
            blocks_left_reg <= '0;
            armed_reg       <= '0;
            pending_reg     <= '0;
            retarget_reg    <= 1'b0;
            dcnt_reg        <= '0;
            scnt_reg        <= '0;
            ramp_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == lrg_pkg::CFG_TICKS_PER_MS)
                begin
                    ticks_reg <= cfg_data[30:0];
                end
                else if (cfg_index == lrg_pkg::CFG_ONE_OVER_N)
                begin
                    oon_reg <= cfg_data[30:0];
                end
            end

            if (cmd.accept)
            begin
                unique case (lrg_pkg::op_t'(din_op))
                    lrg_pkg::OP_SET_TIME:
                    begin
                        pending_reg <= din_value;
                    end
                    lrg_pkg::OP_SET_TARGET:
                    begin
                        target_reg <= din_value;
                        if (pending_reg[31] || (pending_reg == 32'd0))
                        begin
                            current_reg     <= din_value;
                            blocks_left_reg <= '0;
                            retarget_reg    <= 1'b0;
                        end
                        else
                        begin
                            retarget_reg <= 1'b1;
                            armed_reg    <= pending_reg;
                            pending_reg  <= '0;
                        end
                    end
                    lrg_pkg::OP_STOP:
                    begin
                        target_reg      <= current_reg;
                        blocks_left_reg <= '0;
                        retarget_reg    <= 1'b0;
                    end
                    lrg_pkg::OP_TICK:
                    begin
                        scnt_reg <= '0;
                    end
                    default:
                    begin
                        scnt_reg <= '0;
                    end
                endcase
            end

            if (cmd.load_n)
            begin
                blocks_left_reg <= {{FB{n_val[31]}}, n_val[31:FB]};
                retarget_reg    <= 1'b0;
                dcnt_reg        <= '0;
            end

            if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + lrg_pkg::DCNT_W'(1);
            end

            if (cmd.div_fin)
            begin
                block_step_reg <= qneg_reg ? (~quo_low + 32'd1) : quo_low;
            end

            if (cmd.load_s)
            begin
                sample_step_reg <= prod_reg[FB+31:FB];
            end

            if (cmd.prep)
            begin
                ramp_reg <= (blocks_left_reg != 32'd0);
                scnt_reg <= '0;
                if (blocks_left_reg == 32'd0)
                begin
                    current_reg <= target_reg;
                end
            end

            if (cmd.emit_beat)
            begin
                scnt_reg <= scnt_reg + lrg_pkg::SCNT_W'(1);
                if (status.last_beat && ramp_reg)
                begin
                    current_reg     <= current_reg + block_step_reg;
                    blocks_left_reg <= blocks_left_reg - 32'd1;
                end
            end
        end
    end

    // arithmetic payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_n || cmd.mul_s)
        begin
            prod_reg <= prod;
        end

        if (cmd.load_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= num_mag;
            den_reg  <= den_mag;
            qneg_reg <= diff[31] ^ n_val[31];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[31:0] : trial[31:0];
            quo_reg <= {quo_reg[DW-2:0], trial_ge};
        end

        if (cmd.prep)
        begin
            acc_reg <= (blocks_left_reg != 32'd0) ? current_reg : target_reg;
        end
        else if (cmd.emit_beat && ramp_reg)
        begin
            acc_reg <= acc_reg + sample_step_reg;
        end
    end

endmodule
`default_nettype wire

>>> rtl/linear_ramp_generator_top.sv
// Top level: linear ramp generator with event input, sample output and config write channels.
//
// Usage:
//   din carries events (op, value); dout carries samples with a last flag;
//   cfg writes ticks_per_ms (index 0) and one_over_n (index 1), always ready,
//   other indexes are ignored. Write config only while the block is idle.
// Timing:
//   set_target, set_time and stop produce no beats.
//   A tick produces BLOCK_SIZE beats, the final one with last set. A plain
//   tick passes through the prep state before its first beat. A tick that
//   starts a new ramp first runs the block-count multiply, a one-bit-per-
//   cycle divide of the 32+FRAC_BITS-bit dividend and the sample-step
//   multiply, then the prep state, before the first beat.
//   Events are taken one at a time; din is not ready while a block is emitted.
// Reset:
//   Levels, steps and counters clear; config returns to its default values.
// Stall:
//   When dout is not ready the current beat holds and emission pauses.
`default_nettype none
module linear_ramp_generator_top (
    input wire logic  clk,
    input wire logic  rst_n,
    lrg_in_if.sink    din,
    lrg_out_if.source dout,
    lrg_cfg_if.sink   cfg
);

    lrg_pkg::ctrl_cmd_t  cmd;
    lrg_pkg::dp_status_t status;
    logic [31:0]         sample_bits;

    assign cfg.ready = 1'b1;

    lrg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .din_valid  (din.valid),
        .din_op     (din.op),
        .din_ready  (din.ready),
        .dout_valid (dout.valid),
        .dout_ready (dout.ready),
        .status     (status),
        .cmd        (cmd)
    );

    lrg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .din_op    (din.op),
        .din_value (din.value),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .sample    (sample_bits),
        .last      (dout.last)
    );

    assign dout.sample = $signed(sample_bits);

endmodule
`default_nettype wire
